[sv/rgb_matrix_transfer_encode_unit_defines.svh]
// Assertion macros shared by the RGB matrix/transfer encoder RTL.
// No dependencies; included by the top level.
`ifndef RGB_MATRIX_TRANSFER_ENCODE_UNIT_DEFINES_SVH
`define RGB_MATRIX_TRANSFER_ENCODE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RME_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rme assertion failed");
`define RME_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rme assertion failed");
`else
`define RME_ASSERT_IMPLY(label, clk, rst, pre, post)
`define RME_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[sv/rme_pkg.sv]
// Types, constants and helper functions of the RGB matrix/transfer encoder.
// No dependencies; used by rme_lane and the top level.
package rme_pkg;

   localparam int SAMPLE_BITS    = 20;
   localparam int FRAC_BITS      = 15;
   localparam int PARAM_BITS     = 21;
   localparam int CSR_DATA_BITS  = 63;
   localparam int CSR_INDEX_BITS = 3;
   localparam int LOG_STEPS      = 24;
   // matrix 2, prep 1, msb/normalize 2, squaring, exponent mult 2, exp2, final 2
   localparam int LANE_DEPTH     = 2 + 1 + 2 + LOG_STEPS + 2 + LOG_STEPS + 2;

   localparam logic [16:0] ONE_Q15 = 17'd32768;

   localparam logic signed [PARAM_BITS-1:0] SRGB_EXP_Q16   = 21'sd27307;
   localparam logic signed [PARAM_BITS-1:0] BT2020_EXP_Q16 = 21'sd29491;
   localparam logic [16:0]  SRGB_LIN_KNEE  = 17'd102;
   localparam longint       SRGB_LIN_SLOPE = 64'sd846725;
   localparam longint       SRGB_SCALE     = 64'sd69140;
   localparam longint       SRGB_OFFSET    = 64'sd3604;
   localparam longint       BT2020_ONE_Q16 = 64'sd65536;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MATRIX_ROW_ZERO = 3'd0,
      CSR_MATRIX_ROW_ONE  = 3'd1,
      CSR_MATRIX_ROW_TWO  = 3'd2,
      CSR_MODE_FLAGS      = 3'd3,
      CSR_CURVE_SHAPE     = 3'd4,
      CSR_CURVE_LOG       = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      CURVE_LINEAR   = 3'd0,
      CURVE_GAMMA    = 3'd1,
      CURVE_SRGB     = 3'd2,
      CURVE_BT2020   = 3'd3,
      CURVE_PROPHOTO = 3'd4,
      CURVE_LOG      = 3'd5
   } curve_type;

   typedef struct packed {
      logic      apply_curve;
      logic      keep_linear;
      logic      skip_matrix;
      curve_type curve;
   } mode_type;

   typedef struct packed {
      logic signed [PARAM_BITS-1:0] b;
      logic signed [PARAM_BITS-1:0] a;
      logic signed [PARAM_BITS-1:0] ex;
   } shape_type;

   typedef struct packed {
      logic signed [PARAM_BITS-1:0] cutoff;
      logic signed [PARAM_BITS-1:0] d;
      logic signed [PARAM_BITS-1:0] c;
   } log_params_type;

   typedef enum logic [2:0] {
      KIND_DIRECT = 3'd0,
      KIND_LOG    = 3'd1,
      KIND_POW    = 3'd2,
      KIND_SRGB   = 3'd3,
      KIND_BT2020 = 3'd4
   } kind_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] red_in;
      logic signed [SAMPLE_BITS-1:0] green_in;
      logic signed [SAMPLE_BITS-1:0] blue_in;
   } pixel_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] red_out;
      logic signed [SAMPLE_BITS-1:0] green_out;
      logic signed [SAMPLE_BITS-1:0] blue_out;
   } result_type;

   function automatic logic [16:0] clamp_unit(input logic signed [63:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > 64'sd32768) begin
         return ONE_Q15;
      end
      return v[16:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         return hi[SAMPLE_BITS-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_BITS-1:0];
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   // bitwise integer square root, elaboration use only
   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] bit_v;
      n     = n_in;
      r     = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= r + bit_v) begin
            n = n - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   // 2^(-2^-(k+1)) in Q30
   function automatic logic [30:0] exp2_factor(input int k);
      logic [63:0] t;
      t = isqrt64(64'd1 << 59);
      for (int j = 1; j <= k; j++) begin
         t = isqrt64(t << 30);
      end
      return t[30:0];
   endfunction

endpackage

[sv/rgb_matrix_transfer_encode_unit.sv]
// Top level of the RGB 3x3 matrix and transfer-curve encoder.
// Depends on rme_pkg, rme_lane and rgb_matrix_transfer_encode_unit_defines.svh.
//
// Usage:
//  - req_valid/req_stall/req_data carry one linear s4.15 RGB pixel per item;
//    rsp_valid/rsp_stall/rsp_data return one encoded pixel per item, in order.
//  - csr_write/csr_index/csr_wdata write the matrix rows, mode flags and
//    curve parameters; write them only while no item is in flight.
//  - Three channel lanes run side by side; each holds a 57-stage pipeline
//    (matrix row, curve decode, leading-one normalize, 24 log2 squaring
//    stages, exponent multiply, 24 exp2 factor stages, final scaling). The
//    output register merges the three lane results into one item.
//  - Throughput: one item per clock while the receiver does not stall; the
//    two 24-step multiplier chains make up most of the pipeline depth.
//  - When the receiver stalls, the output register holds; the pipeline keeps
//    moving as long as its last stage is empty, so bubbles are squeezed out
//    and input keeps flowing until the stage in front of the output fills.
//  - Reset (synchronous) empties the pipeline and loads the identity matrix,
//    and clears mode and curve registers.
`include "rgb_matrix_transfer_encode_unit_defines.svh"
module rgb_matrix_transfer_encode_unit #(
   parameter int COEFF_BITS = 18
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rme_pkg::pixel_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rme_pkg::result_type                   rsp_data,
   input  logic                                  csr_write,
   input  logic [rme_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rme_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int ROW_BITS = 3 * COEFF_BITS;
   localparam int DEPTH    = rme_pkg::LANE_DEPTH;
   localparam logic [ROW_BITS-1:0] UNIT_COEF = ROW_BITS'(1 << rme_pkg::FRAC_BITS);

   // configuration registers
   logic [ROW_BITS-1:0]      row_ff [3];
   rme_pkg::mode_type        mode_ff;
   rme_pkg::shape_type       shape_ff;
   rme_pkg::log_params_type  logp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            row_ff[i] <= UNIT_COEF << (i * COEFF_BITS);
         end
         mode_ff  <= '0;
         shape_ff <= '0;
         logp_ff  <= '0;
      end else if (csr_write) begin
         unique case (rme_pkg::csr_index_type'(csr_index))
            rme_pkg::CSR_MATRIX_ROW_ZERO: row_ff[0] <= csr_wdata[ROW_BITS-1:0];
            rme_pkg::CSR_MATRIX_ROW_ONE:  row_ff[1] <= csr_wdata[ROW_BITS-1:0];
            rme_pkg::CSR_MATRIX_ROW_TWO:  row_ff[2] <= csr_wdata[ROW_BITS-1:0];
            rme_pkg::CSR_MODE_FLAGS:      mode_ff   <= csr_wdata[5:0];
            rme_pkg::CSR_CURVE_SHAPE:     shape_ff  <= csr_wdata;
            rme_pkg::CSR_CURVE_LOG:       logp_ff   <= csr_wdata;
            default: begin
               // indexes past the register list are dropped
            end
         endcase
      end
   end

   // flow control: output register loads when empty or taken; the pipe
   // moves when the output loads or its last stage holds nothing
   logic       out_load;
   logic       adv;
   logic [DEPTH-1:0] vld_ff;
   logic       rsp_valid_ff;
   rme_pkg::result_type rsp_data_ff;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign adv       = out_load || !vld_ff[DEPTH-1];
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // channel lanes
   logic signed [rme_pkg::SAMPLE_BITS-1:0] own_px  [3];
   logic signed [rme_pkg::SAMPLE_BITS-1:0] lane_res [3];

   assign own_px[0] = req_data.red_in;
   assign own_px[1] = req_data.green_in;
   assign own_px[2] = req_data.blue_in;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      rme_lane #(
         .COEFF_BITS (COEFF_BITS)
      ) u_lane (
         .clock      (clock),
         .adv        (adv),
         .row_coef   (row_ff[i]),
         .mode       (mode_ff),
         .shape      (shape_ff),
         .logp       (logp_ff),
         .pixel      (req_data),
         .own_sample (own_px[i]),
         .result     (lane_res[i])
      );
   end

   // merge stage: the three lane results become one item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && vld_ff[DEPTH-1]) begin
         rsp_data_ff.red_out   <= lane_res[0];
         rsp_data_ff.green_out <= lane_res[1];
         rsp_data_ff.blue_out  <= lane_res[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an accepted item enters the first stage
   `RME_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, vld_ff[0])
   // a finished item in the last stage reaches the output when the pipe moves
   `RME_ASSERT_NEXT(a_last_to_out, clock, reset, vld_ff[DEPTH-1] && !req_stall, rsp_valid_ff)
   // a taken result with nothing behind it leaves the output empty
   `RME_ASSERT_NEXT(a_drain, clock, reset, rsp_valid_ff && !rsp_stall && !vld_ff[DEPTH-1], !rsp_valid_ff)

endmodule

[sv/rme_lane.sv]
// One color channel: matrix row, curve selection, log2 squaring pipe,
// exponent pipe and final scaling. Depends on rme_pkg.
module rme_lane #(
   parameter int COEFF_BITS = 18
) (
   input  logic                                   clock,
   input  logic                                   adv,
   input  logic [3*COEFF_BITS-1:0]                row_coef,
   input  rme_pkg::mode_type                      mode,
   input  rme_pkg::shape_type                     shape,
   input  rme_pkg::log_params_type                logp,
   input  rme_pkg::pixel_type                     pixel,
   input  logic signed [rme_pkg::SAMPLE_BITS-1:0] own_sample,
   output logic signed [rme_pkg::SAMPLE_BITS-1:0] result
);

   localparam int SB   = rme_pkg::SAMPLE_BITS;
   localparam int CB   = COEFF_BITS;
   localparam int FB   = rme_pkg::FRAC_BITS;
   localparam int NS   = rme_pkg::LOG_STEPS;
   localparam int PW   = SB + CB;
   localparam int SW   = PW + 2;
   localparam int DW   = (SB > 17) ? SB : 17;
   localparam int AW   = ((SB > 21) ? SB : 21) + 2;
   localparam int MBW  = $clog2(AW - 1);

   typedef struct packed {
      rme_pkg::kind_type       kind;
      logic                    x_zero;
      logic signed [DW-1:0]    direct;
   } side_type;

   // ---------------- matrix row
   logic signed [SB-1:0] px [3];
   logic signed [CB-1:0] coef [3];
   logic signed [PW-1:0] prod_ff [3];
   logic signed [SB-1:0] own_ff;
   logic signed [SW-1:0] sum_s;
   logic signed [SW-1:0] rnd_s;
   logic signed [SB-1:0] lin_in;
   logic signed [SB-1:0] lin_ff;

   assign px[0] = pixel.red_in;
   assign px[1] = pixel.green_in;
   assign px[2] = pixel.blue_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         coef[k] = row_coef[k*CB +: CB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= PW'(coef[k]) * PW'(px[k]);
         end
         own_ff <= own_sample;
      end
   end

   always_comb begin
      sum_s  = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]);
      rnd_s  = (sum_s + SW'(1 <<< (FB - 1))) >>> FB;
      lin_in = mode.skip_matrix ? own_ff : rme_pkg::sat_sample(64'(rnd_s));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_ff <= lin_in;
      end
   end

   // ---------------- curve decode and linear segments
   logic [16:0]          x_u;
   logic [SB-2:0]        xl_u;
   logic signed [AW-1:0] s_v;
   logic signed [63:0]   t_srgb_lin;
   logic signed [63:0]   t_log_lin;
   side_type             side_in;
   logic [AW-2:0]        arg_in;
   logic                 fb16_in;
   side_type             side_p_ff;
   logic [AW-2:0]        arg_p_ff;
   logic                 fb16_p_ff;

   always_comb begin
      x_u        = rme_pkg::clamp_unit(64'(lin_ff));
      xl_u       = lin_ff[SB-1] ? '0 : lin_ff[SB-2:0];
      s_v        = AW'($signed({1'b0, xl_u, 1'b0})) + AW'(shape.a);
      t_srgb_lin = $signed(64'(x_u)) * rme_pkg::SRGB_LIN_SLOPE;
      t_log_lin  = 64'($signed({1'b0, xl_u})) * 64'(logp.d);

      side_in.kind   = rme_pkg::KIND_DIRECT;
      side_in.x_zero = (x_u == '0);
      side_in.direct = DW'(lin_ff);
      arg_in         = (AW-1)'(x_u);
      fb16_in        = 1'b0;

      if (mode.keep_linear) begin
         side_in.direct = DW'(lin_ff);
      end else if (!mode.apply_curve) begin
         side_in.direct = DW'(x_u);
      end else begin
         unique case (mode.curve)
            rme_pkg::CURVE_LINEAR: begin
               side_in.direct = DW'(lin_ff);
            end
            rme_pkg::CURVE_GAMMA: begin
               side_in.kind = rme_pkg::KIND_POW;
            end
            rme_pkg::CURVE_SRGB: begin
               if (x_u <= rme_pkg::SRGB_LIN_KNEE) begin
                  side_in.direct = DW'(rme_pkg::clamp_unit(
                     (t_srgb_lin + 64'sd32768) >>> 16));
               end else begin
                  side_in.kind = rme_pkg::KIND_SRGB;
               end
            end
            rme_pkg::CURVE_BT2020: begin
               if ($signed({1'b0, x_u, 1'b0}) < shape.b) begin
                  side_in.direct = DW'(rme_pkg::clamp_unit(
                     ($signed(64'(x_u)) * 64'sd9 + 64'sd1) >>> 1));
               end else begin
                  side_in.kind = rme_pkg::KIND_BT2020;
               end
            end
            rme_pkg::CURVE_PROPHOTO: begin
               if ($signed({1'b0, x_u, 1'b0}) < logp.cutoff) begin
                  side_in.direct = DW'(rme_pkg::clamp_unit($signed(64'({x_u, 4'b0}))));
               end else begin
                  side_in.kind = rme_pkg::KIND_POW;
               end
            end
            rme_pkg::CURVE_LOG: begin
               if ($signed({1'b0, xl_u, 1'b0}) <= logp.cutoff) begin
                  side_in.direct = DW'(rme_pkg::clamp_unit(
                     (t_log_lin + 64'sd32768) >>> 16));
               end else if (s_v[AW-1] || (s_v == '0)) begin
                  side_in.direct = '0;
               end else begin
                  side_in.kind = rme_pkg::KIND_LOG;
                  arg_in       = s_v[AW-2:0];
                  fb16_in      = 1'b1;
               end
            end
            default: begin
               side_in.direct = DW'(x_u);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_p_ff <= side_in;
         arg_p_ff  <= arg_in;
         fb16_p_ff <= fb16_in;
      end
   end

   // ---------------- leading one search, then normalize to Q30
   logic [MBW-1:0]       msb_in;
   side_type             side_m_ff;
   logic [AW-2:0]        arg_m_ff;
   logic                 fb16_m_ff;
   logic [MBW-1:0]       msb_m_ff;

   always_comb begin
      msb_in = '0;
      for (int i = 0; i < AW - 1; i++) begin
         if (arg_p_ff[i]) begin
            msb_in = MBW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_m_ff <= side_p_ff;
         arg_m_ff  <= arg_p_ff;
         fb16_m_ff <= fb16_p_ff;
         msb_m_ff  <= msb_in;
      end
   end

   logic [AW+29:0]       norm_ext;
   logic [AW+29:0]       norm_sh;

   side_type             sq_side_ff [NS+1];
   logic [30:0]          sq_m_ff    [NS+1];
   logic [NS-1:0]        sq_frac_ff [NS+1];
   logic signed [6:0]    sq_exp_ff  [NS+1];

   always_comb begin
      norm_ext = {arg_m_ff, 31'b0};
      norm_sh  = norm_ext << (MBW'(AW - 2) - msb_m_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= side_m_ff;
         sq_m_ff[0]    <= norm_sh[AW+29 -: 31];
         sq_frac_ff[0] <= '0;
         sq_exp_ff[0]  <= $signed(7'(msb_m_ff)) - (fb16_m_ff ? 7'sd16 : 7'sd15);
      end
   end

   // ---------------- log2 fraction: one squaring per stage
   for (genvar j = 0; j < NS; j++) begin : g_sq
      logic [61:0] sq_full;
      logic [31:0] sq_raw;

      always_comb begin
         sq_full = 62'(sq_m_ff[j]) * 62'(sq_m_ff[j]);
         sq_raw  = sq_full[61:30];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_side_ff[j+1] <= sq_side_ff[j];
            sq_exp_ff[j+1]  <= sq_exp_ff[j];
            sq_m_ff[j+1]    <= sq_raw[31] ? sq_raw[31:1] : sq_raw[30:0];
            sq_frac_ff[j+1] <= {sq_frac_ff[j][NS-2:0], sq_raw[31]};
         end
      end
   end

   // ---------------- exponent times log2, log curve scale
   logic signed [30:0]   log2_v;
   logic signed [20:0]   e_sel;
   side_type             side_a_ff;
   logic signed [51:0]   y_a_ff;
   logic signed [31:0]   t_a_ff;

   always_comb begin
      log2_v = $signed({sq_exp_ff[NS], sq_frac_ff[NS]});
      unique case (sq_side_ff[NS].kind)
         rme_pkg::KIND_SRGB:   e_sel = rme_pkg::SRGB_EXP_Q16;
         rme_pkg::KIND_BT2020: e_sel = rme_pkg::BT2020_EXP_Q16;
         default:              e_sel = shape.ex;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_a_ff <= sq_side_ff[NS];
         y_a_ff    <= 52'(e_sel) * 52'(log2_v);
         t_a_ff    <= 32'(log2_v) + (32'(shape.b) <<< 8);
      end
   end

   logic signed [51:0]   n_neg;
   side_type             side_b_ff;
   logic signed [52:0]   tc_b_ff;
   logic                 ynn_b_ff;
   logic                 big_b_ff;
   logic [4:0]           ip_b_ff;
   logic [NS-1:0]        f_b_ff;

   assign n_neg = -y_a_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         side_b_ff <= side_a_ff;
         tc_b_ff   <= 53'(t_a_ff) * 53'(logp.c);
         ynn_b_ff  <= !y_a_ff[51];
         big_b_ff  <= (n_neg[51:40] > 12'd30);
         ip_b_ff   <= n_neg[44:40];
         f_b_ff    <= n_neg[39:16];
      end
   end

   // ---------------- 2^-f: one conditional factor per stage
   side_type             ex_side_ff [NS];
   logic [30:0]          ex_r_ff    [NS];
   logic [NS-1:0]        ex_f_ff    [NS];
   logic                 ex_ynn_ff  [NS];
   logic                 ex_big_ff  [NS];
   logic [4:0]           ex_ip_ff   [NS];

   for (genvar k = 0; k < NS; k++) begin : g_exp
      localparam logic [30:0] FACTOR = rme_pkg::exp2_factor(k);
      side_type    side_src;
      logic [30:0] r_src;
      logic [NS-1:0] f_src;
      logic        ynn_src;
      logic        big_src;
      logic [4:0]  ip_src;
      logic [61:0] r_prod;

      if (k == 0) begin : g_first
         // log curve result is finished here
         always_comb begin
            side_src = side_b_ff;
            if (side_b_ff.kind == rme_pkg::KIND_LOG) begin
               side_src.kind   = rme_pkg::KIND_DIRECT;
               side_src.direct = DW'(rme_pkg::clamp_unit(
                  (64'(tc_b_ff) + (64'sd1 <<< 24)) >>> 25));
            end
            r_src   = 31'(1 << 30);
            f_src   = f_b_ff;
            ynn_src = ynn_b_ff;
            big_src = big_b_ff;
            ip_src  = ip_b_ff;
         end
      end else begin : g_next
         always_comb begin
            side_src = ex_side_ff[k-1];
            r_src    = ex_r_ff[k-1];
            f_src    = ex_f_ff[k-1];
            ynn_src  = ex_ynn_ff[k-1];
            big_src  = ex_big_ff[k-1];
            ip_src   = ex_ip_ff[k-1];
         end
      end

      assign r_prod = 62'(r_src) * 62'(FACTOR);

      always_ff @(posedge clock) begin
         if (adv) begin
            ex_side_ff[k] <= side_src;
            ex_r_ff[k]    <= f_src[NS-1-k] ? r_prod[60:30] : r_src;
            ex_f_ff[k]    <= f_src;
            ex_ynn_ff[k]  <= ynn_src;
            ex_big_ff[k]  <= big_src;
            ex_ip_ff[k]   <= ip_src;
         end
      end
   end

   // ---------------- power result, then curve scaling
   logic [31:0]          r_shift;
   logic [30:0]          p_in;
   side_type             side_f1_ff;
   logic [30:0]          p_f1_ff;

   always_comb begin
      r_shift = 32'(ex_r_ff[NS-1]);
      if (ex_ip_ff[NS-1] != '0) begin
         r_shift = (r_shift + (32'd1 << (ex_ip_ff[NS-1] - 5'd1))) >> ex_ip_ff[NS-1];
      end
      if (ex_side_ff[NS-1].x_zero) begin
         // zero base: one only for a zero exponent
         p_in = ((ex_side_ff[NS-1].kind == rme_pkg::KIND_POW) && (shape.ex == '0))
                ? 31'(1 << 30) : '0;
      end else if (ex_ynn_ff[NS-1]) begin
         p_in = 31'(1 << 30);
      end else if (ex_big_ff[NS-1]) begin
         p_in = '0;
      end else begin
         p_in = r_shift[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_f1_ff <= ex_side_ff[NS-1];
         p_f1_ff    <= p_in;
      end
   end

   side_type             side_f2_ff;
   logic [30:0]          p_f2_ff;
   logic [47:0]          ps_f2_ff;
   logic signed [52:0]   pb_f2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         side_f2_ff <= side_f1_ff;
         p_f2_ff    <= p_f1_ff;
         ps_f2_ff   <= 48'(p_f1_ff) * 48'(rme_pkg::SRGB_SCALE);
         pb_f2_ff   <= 53'(shape.a) * 53'($signed({1'b0, p_f1_ff}));
      end
   end

   logic signed [63:0]   t_fin;
   logic [16:0]          enc_v;

   always_comb begin
      t_fin = '0;
      enc_v = '0;
      unique case (side_f2_ff.kind)
         rme_pkg::KIND_POW: begin
            enc_v = rme_pkg::clamp_unit($signed(64'(p_f2_ff) + 64'sd16384) >>> 15);
         end
         rme_pkg::KIND_SRGB: begin
            t_fin = $signed(64'(ps_f2_ff)) - (rme_pkg::SRGB_OFFSET <<< 30);
            enc_v = rme_pkg::clamp_unit((t_fin + (64'sd1 <<< 30)) >>> 31);
         end
         rme_pkg::KIND_BT2020: begin
            t_fin = 64'(pb_f2_ff) - ((64'(shape.a) - rme_pkg::BT2020_ONE_Q16) <<< 30);
            enc_v = rme_pkg::clamp_unit((t_fin + (64'sd1 <<< 30)) >>> 31);
         end
         default: begin
            enc_v = '0;
         end
      endcase
      if (side_f2_ff.kind == rme_pkg::KIND_DIRECT || side_f2_ff.kind == rme_pkg::KIND_LOG) begin
         result = rme_pkg::sat_sample(64'(side_f2_ff.direct));
      end else begin
         result = rme_pkg::sat_sample($signed(64'(enc_v)));
      end
   end

endmodule
